FILE: hdl/kbpfe_pkg.sv
// ----------------------------------------------------------------------------
// kbpfe_pkg
// Shared types, command codes and key constants of the keypad bus frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

package kbpfe_pkg;

    // Request command codes
    typedef enum logic [2:0]
    {
        CMD_LOAD  = 3'd0,
        CMD_START = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_POP   = 3'd3,
        CMD_READ  = 3'd4
    } kbpfe_cmd_t;

    // Request beat
    typedef struct packed
    {
        logic [2:0] command;
        logic [3:0] byte_index;
        logic [7:0] byte_value;
        logic [3:0] frame_bytes;
        logic       data_level;
    } kbpfe_in_t;

    // Result beat
    typedef struct packed
    {
        logic       clock_level;
        logic       data_pull;
        logic       busy_res;
        logic       frame_done;
        logic       key_valid;
        logic [7:0] key_code;
        logic       alarm_key_seen;
        logic       alarm_reply_pending;
        logic       key_overflow;
        logic [7:0] module_byte;
    } kbpfe_out_t;

    // Frame opcodes and bus byte values
    localparam logic [7:0] VERIFY_OPCODE    = 8'h1C;
    localparam logic [7:0] PARTITION_OPCODE = 8'h05;
    localparam logic [7:0] IDLE_BYTE        = 8'hFF;

    // Alarm keys as seen on the bus, and the codes they are queued as
    localparam logic [7:0] ALARM_BUS_A = 8'hBB;
    localparam logic [7:0] ALARM_BUS_B = 8'hDD;
    localparam logic [7:0] ALARM_BUS_C = 8'hEE;
    localparam logic [7:0] ALARM_KEY_A = 8'h0B;
    localparam logic [7:0] ALARM_KEY_B = 8'h0D;
    localparam logic [7:0] ALARM_KEY_C = 8'h0E;

    // Bit counters only need to tell "before", "at" and "past" the stop bit
    localparam logic [3:0] STOP_TOTAL = 4'd8;
    localparam logic [3:0] TOTAL_SAT  = 4'd9;

    // Half-cycles added to every frame on top of sixteen per command byte
    localparam int FRAME_TAIL = 4;

    localparam int NUM_ACCEPTED = 24;
    localparam logic [7:0] ACCEPTED_KEYS [NUM_ACCEPTED] = '{
        8'h00, 8'h05, 8'h0A, 8'h0F, 8'h11, 8'h16, 8'h1B, 8'h1C,
        8'h22, 8'h27, 8'h28, 8'h2D, 8'h82, 8'h87, 8'h88, 8'hAF,
        8'hB1, 8'hBB, 8'hDA, 8'hE1, 8'hF7, 8'h0B, 8'h0D, 8'h0E
    };

    // True when a popped code is one the panel acts on
    function automatic logic key_accepted(input logic [7:0] code);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_ACCEPTED; i++)
        begin
            if (ACCEPTED_KEYS[i] == code)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/keybus_panel_frame_engine.sv
// ----------------------------------------------------------------------------
// keybus_panel_frame_engine
// Panel-side master of a keypad bus: frame sequencing, bit capture, key queue.
// ----------------------------------------------------------------------------
//
//  channel | signals                         | beat taken when
//  --------+---------------------------------+-------------------------------
//  request | req_valid, req_stall, req_data  | req_valid high, req_stall low
//  result  | rsp_valid, rsp_stall, rsp_data  | rsp_valid high, rsp_stall low
//
//  One request beat yields exactly one result beat, via the request register
//  and the result register; one beat per cycle is sustained while the result
//  side does not stall. Both registers bound a single layer of update logic.
//  rst_n clears all control state, the capture and latched module bytes, the
//  key counters and the status flags; command slots and key entries are not
//  cleared. A stall on the result side holds the result register and backs up
//  through the request register into req_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module keybus_panel_frame_engine
    import kbpfe_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 12,
    parameter int READ_BYTES      = 16,
    parameter int KEY_DEPTH       = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire kbpfe_in_t  req_data,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output kbpfe_out_t      rsp_data
);

    // Counter widths
    localparam int FL_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LIM_W = FL_W + 5;
    localparam int IBY_W = $clog2(READ_BYTES + 1);
    localparam int KC_W  = $clog2(KEY_DEPTH + 1);
    localparam int KP_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    // ------------------------------------------------------------------
    // Handshake registers
    // ------------------------------------------------------------------
    kbpfe_in_t  req_reg;
    logic       req_full_reg;
    logic       rsp_valid_reg;
    kbpfe_out_t rsp_reg;
    kbpfe_out_t rsp_next;
    logic       advance;

    // ------------------------------------------------------------------
    // Engine state
    // ------------------------------------------------------------------
    logic [7:0]       fs_reg   [MAX_FRAME_BYTES];
    logic [7:0]       fs_next  [MAX_FRAME_BYTES];
    logic [7:0]       cap_reg  [READ_BYTES];
    logic [7:0]       cap_next [READ_BYTES];
    logic [7:0]       lat_reg  [READ_BYTES];
    logic [7:0]       lat_next [READ_BYTES];
    logic [7:0]       fifo_reg [KEY_DEPTH];
    logic [7:0]       fifo_next[KEY_DEPTH];

    logic [FL_W-1:0]  frame_len_reg,  frame_len_next;
    logic [7:0]       half_reg,       half_next;
    logic             phase_high_reg, phase_high_next;
    logic [2:0]       in_bit_reg,     in_bit_next;
    logic [IBY_W-1:0] in_byte_reg,    in_byte_next;
    logic [3:0]       in_tot_reg,     in_tot_next;
    logic [2:0]       out_bit_reg,    out_bit_next;
    logic [FL_W-1:0]  out_byte_reg,   out_byte_next;
    logic [3:0]       out_tot_reg,    out_tot_next;
    logic             low_seen_reg,   low_seen_next;
    logic [KC_W-1:0]  key_count_reg,  key_count_next;
    logic [KP_W-1:0]  key_rd_reg,     key_rd_next;
    logic             busy_reg,       busy_next;
    logic             alarm_reg,      alarm_next;
    logic             pending_reg,    pending_next;
    logic             overflow_reg,   overflow_next;
    logic             clock_pin_reg,  clock_pin_next;
    logic             pull_pin_reg,   pull_pin_next;

    // Per-item working signals
    logic [LIM_W-1:0] frame_limit;
    logic [7:0]       fs_sel;
    logic [7:0]       pop_code;
    logic [KC_W-1:0]  key_rd_inc;
    logic             push_en;
    logic [7:0]       push_code;
    logic             done;
    logic             kvalid;
    logic [7:0]       kcode;
    logic [7:0]       mbyte;

    // ------------------------------------------------------------------
    // Flow control: advance the held request whenever the result register
    // is empty or being emptied this cycle
    // ------------------------------------------------------------------
    assign advance   = req_full_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_full_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_full_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                req_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_full_reg <= 1'b0;
            end

            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on a taken beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req_data;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Frame length in half-cycles: sixteen per byte plus the tail
    assign frame_limit = LIM_W'({frame_len_reg, 4'b0000}) + LIM_W'(FRAME_TAIL);

    // Command byte currently on the wire
    always_comb
    begin
        fs_sel = '0;
        for (int i = 0; i < MAX_FRAME_BYTES; i++)
        begin
            if (32'(out_byte_reg) == i)
            begin
                fs_sel = fs_reg[i];
            end
        end
    end

    // Head of the key queue
    always_comb
    begin
        pop_code = '0;
        for (int i = 0; i < KEY_DEPTH; i++)
        begin
            if (32'(key_rd_reg) == i)
            begin
                pop_code = fifo_reg[i];
            end
        end
    end

    assign key_rd_inc = KC_W'(key_rd_reg) + KC_W'(1);

    // ------------------------------------------------------------------
    // Single-pass update of the whole engine for the held request
    // ------------------------------------------------------------------
    always_comb
    begin
        fs_next         = fs_reg;
        cap_next        = cap_reg;
        lat_next        = lat_reg;
        fifo_next       = fifo_reg;
        frame_len_next  = frame_len_reg;
        half_next       = half_reg;
        phase_high_next = phase_high_reg;
        in_bit_next     = in_bit_reg;
        in_byte_next    = in_byte_reg;
        in_tot_next     = in_tot_reg;
        out_bit_next    = out_bit_reg;
        out_byte_next   = out_byte_reg;
        out_tot_next    = out_tot_reg;
        low_seen_next   = low_seen_reg;
        key_count_next  = key_count_reg;
        key_rd_next     = key_rd_reg;
        busy_next       = busy_reg;
        alarm_next      = alarm_reg;
        pending_next    = pending_reg;
        overflow_next   = overflow_reg;
        clock_pin_next  = clock_pin_reg;
        pull_pin_next   = pull_pin_reg;
        push_en         = 1'b0;
        push_code       = '0;
        done            = 1'b0;
        kvalid          = 1'b0;
        kcode           = '0;
        mbyte           = '0;

        if (advance)
        begin
            unique case (req_reg.command)
                CMD_LOAD:
                begin
                    if (!busy_reg && 32'(req_reg.byte_index) < MAX_FRAME_BYTES)
                    begin
                        for (int i = 0; i < MAX_FRAME_BYTES; i++)
                        begin
                            if (32'(req_reg.byte_index) == i)
                            begin
                                fs_next[i] = req_reg.byte_value;
                            end
                        end
                    end
                end

                CMD_START:
                begin
                    if (!busy_reg)
                    begin
                        // Saturate the length to the slot count
                        if (32'(req_reg.frame_bytes) > MAX_FRAME_BYTES)
                        begin
                            frame_len_next = FL_W'(MAX_FRAME_BYTES);
                        end
                        else
                        begin
                            frame_len_next = FL_W'(req_reg.frame_bytes);
                        end
                        half_next = '0;
                        busy_next = 1'b1;
                        if (fs_reg[0] == VERIFY_OPCODE)
                        begin
                            alarm_next   = 1'b0;
                            pending_next = 1'b1;
                        end
                    end
                end

                CMD_TICK:
                begin
                    if (busy_reg && 32'(half_reg) < 32'(frame_limit))
                    begin
                        half_next = half_reg + 8'd1;
                        if (phase_high_reg)
                        begin
                            // Rising phase: raise clock, release data
                            phase_high_next = 1'b0;
                            clock_pin_next  = 1'b1;
                            pull_pin_next   = 1'b0;
                        end
                        else
                        begin
                            phase_high_next = 1'b1;
                            clock_pin_next  = 1'b0;

                            // Shift in one module bit
                            if (32'(in_byte_reg) < READ_BYTES)
                            begin
                                for (int i = 0; i < READ_BYTES; i++)
                                begin
                                    if (32'(in_byte_reg) == i)
                                    begin
                                        cap_next[i] = {cap_reg[i][6:0],
                                                       req_reg.data_level};
                                    end
                                end
                                if (!req_reg.data_level)
                                begin
                                    low_seen_next = 1'b1;
                                end
                                if (in_tot_reg == STOP_TOTAL)
                                begin
                                    // Stop bit sits alone in byte 1
                                    cap_next[1]  = 8'h01;
                                    in_bit_next  = '0;
                                    in_byte_next = in_byte_reg + IBY_W'(1);
                                end
                                else if (in_bit_reg != 3'd7)
                                begin
                                    in_bit_next = in_bit_reg + 3'd1;
                                end
                                else
                                begin
                                    in_bit_next  = '0;
                                    in_byte_next = in_byte_reg + IBY_W'(1);
                                end
                                if (in_tot_reg != TOTAL_SAT)
                                begin
                                    in_tot_next = in_tot_reg + 4'd1;
                                end
                            end

                            // Drive one inverted command bit or the stop bit
                            if (out_tot_reg == STOP_TOTAL)
                            begin
                                pull_pin_next = 1'b1;
                                if (fs_reg[0] == VERIFY_OPCODE)
                                begin
                                    pending_next = 1'b0;
                                    if (cap_next[0] != IDLE_BYTE)
                                    begin
                                        if (32'(key_count_reg) >= KEY_DEPTH)
                                        begin
                                            overflow_next = 1'b1;
                                        end
                                        else if (cap_next[0] == ALARM_BUS_A)
                                        begin
                                            push_en   = 1'b1;
                                            push_code = ALARM_KEY_A;
                                        end
                                        else if (cap_next[0] == ALARM_BUS_B)
                                        begin
                                            push_en   = 1'b1;
                                            push_code = ALARM_KEY_B;
                                        end
                                        else if (cap_next[0] == ALARM_BUS_C)
                                        begin
                                            push_en   = 1'b1;
                                            push_code = ALARM_KEY_C;
                                        end
                                    end
                                end
                                out_tot_next = TOTAL_SAT;
                            end
                            else if (out_bit_reg == 3'd7)
                            begin
                                if (32'(out_byte_reg) < MAX_FRAME_BYTES && !fs_sel[0])
                                begin
                                    pull_pin_next = 1'b1;
                                end
                                out_bit_next  = '0;
                                out_byte_next = out_byte_reg + FL_W'(1);
                                if (out_tot_reg != TOTAL_SAT)
                                begin
                                    out_tot_next = out_tot_reg + 4'd1;
                                end
                            end
                            else if (out_byte_reg < frame_len_reg &&
                                     32'(out_byte_reg) < MAX_FRAME_BYTES)
                            begin
                                if (!fs_sel[3'd7 - out_bit_reg])
                                begin
                                    pull_pin_next = 1'b1;
                                end
                                out_bit_next = out_bit_reg + 3'd1;
                                if (out_tot_reg != TOTAL_SAT)
                                begin
                                    out_tot_next = out_tot_reg + 4'd1;
                                end
                            end
                        end
                    end
                    else if (busy_reg)
                    begin
                        // Frame end: latch module bytes, flag and queue keys
                        done           = 1'b1;
                        clock_pin_next = 1'b0;
                        if (low_seen_reg)
                        begin
                            low_seen_next = 1'b0;
                            lat_next      = cap_reg;
                            if (cap_reg[0] != IDLE_BYTE && fs_reg[0] != VERIFY_OPCODE)
                            begin
                                alarm_next = 1'b1;
                            end
                            if (cap_reg[2] != IDLE_BYTE && fs_reg[0] == PARTITION_OPCODE)
                            begin
                                push_en   = 1'b1;
                                push_code = cap_reg[2];
                            end
                        end
                        for (int i = 0; i < READ_BYTES; i++)
                        begin
                            cap_next[i] = '0;
                        end
                        in_bit_next   = '0;
                        in_byte_next  = '0;
                        in_tot_next   = '0;
                        out_bit_next  = '0;
                        out_byte_next = '0;
                        out_tot_next  = '0;
                        busy_next     = 1'b0;
                    end
                end

                CMD_POP:
                begin
                    if (key_count_reg != '0)
                    begin
                        kcode  = pop_code;
                        kvalid = key_accepted(pop_code);
                        if (key_rd_inc >= key_count_reg)
                        begin
                            key_rd_next    = '0;
                            key_count_next = '0;
                        end
                        else
                        begin
                            key_rd_next = KP_W'(key_rd_inc);
                        end
                    end
                end

                CMD_READ:
                begin
                    for (int i = 0; i < READ_BYTES; i++)
                    begin
                        if (32'(req_reg.byte_index) == i)
                        begin
                            mbyte = lat_reg[i];
                        end
                    end
                end

                default:
                begin
                end
            endcase

            // Queue a key, or drop it and flag overflow when full
            if (push_en)
            begin
                if (32'(key_count_reg) >= KEY_DEPTH)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < KEY_DEPTH; i++)
                    begin
                        if (32'(key_count_reg) == i)
                        begin
                            fifo_next[i] = push_code;
                        end
                    end
                    key_count_next = key_count_reg + KC_W'(1);
                end
            end
        end

        rsp_next.clock_level         = clock_pin_next;
        rsp_next.data_pull           = pull_pin_next;
        rsp_next.busy_res            = busy_next;
        rsp_next.frame_done          = done;
        rsp_next.key_valid           = kvalid;
        rsp_next.key_code            = kcode;
        rsp_next.alarm_key_seen      = alarm_next;
        rsp_next.alarm_reply_pending = pending_next;
        rsp_next.key_overflow        = overflow_next;
        rsp_next.module_byte         = mbyte;
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < READ_BYTES; i++)
            begin
                cap_reg[i] <= '0;
                lat_reg[i] <= '0;
            end
            frame_len_reg  <= '0;
            half_reg       <= '0;
            phase_high_reg <= 1'b1;
            in_bit_reg     <= '0;
            in_byte_reg    <= '0;
            in_tot_reg     <= '0;
            out_bit_reg    <= '0;
            out_byte_reg   <= '0;
            out_tot_reg    <= '0;
            low_seen_reg   <= 1'b0;
            key_count_reg  <= '0;
            key_rd_reg     <= '0;
            busy_reg       <= 1'b0;
            alarm_reg      <= 1'b0;
            pending_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            clock_pin_reg  <= 1'b0;
            pull_pin_reg   <= 1'b0;
        end
        else
        begin
            cap_reg        <= cap_next;
            lat_reg        <= lat_next;
            frame_len_reg  <= frame_len_next;
            half_reg       <= half_next;
            phase_high_reg <= phase_high_next;
            in_bit_reg     <= in_bit_next;
            in_byte_reg    <= in_byte_next;
            in_tot_reg     <= in_tot_next;
            out_bit_reg    <= out_bit_next;
            out_byte_reg   <= out_byte_next;
            out_tot_reg    <= out_tot_next;
            low_seen_reg   <= low_seen_next;
            key_count_reg  <= key_count_next;
            key_rd_reg     <= key_rd_next;
            busy_reg       <= busy_next;
            alarm_reg      <= alarm_next;
            pending_reg    <= pending_next;
            overflow_reg   <= overflow_next;
            clock_pin_reg  <= clock_pin_next;
            pull_pin_reg   <= pull_pin_next;
        end
    end

    // Command slots and key entries carry no reset
    always_ff @(posedge clk)
    begin
        fs_reg   <= fs_next;
        fifo_reg <= fifo_next;
    end

endmodule

`default_nettype wire

FILE: hdl/kbpfe_checker.sv
// ----------------------------------------------------------------------------
// kbpfe_checker
// Port-level checks on the keypad bus frame engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kbpfe_checker
    import kbpfe_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_stall,
    input wire kbpfe_out_t rsp_data
);

    logic ovf_seen_reg;

    // Remember an overflow once a beat has reported it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_seen_reg <= 1'b0;
        end
        else if (rsp_valid && !rsp_stall && rsp_data.key_overflow)
        begin
            ovf_seen_reg <= 1'b1;
        end
    end

    // A stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("result beat changed while stalled");

    // Overflow stays set until reset
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ovf_seen_reg |-> rsp_data.key_overflow)
        else $error("key overflow flag cleared");

    // A completed frame leaves the engine idle with the clock low
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.frame_done |-> !rsp_data.busy_res && !rsp_data.clock_level)
        else $error("frame done while still busy");

    // Key and module byte fields never appear in the same beat
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.key_valid || rsp_data.key_code != 8'h00)
        |-> rsp_data.module_byte == 8'h00 && !rsp_data.frame_done)
        else $error("pop result mixed with other fields");

endmodule

bind keybus_panel_frame_engine kbpfe_checker u_kbpfe_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad bus frame engine. Request beats are
// mirrored into a cycle-free model of the panel state and each result beat is
// checked field by field against the oldest outstanding prediction. Traffic is
// mostly complete frames with shaped module replies, mixed with stray beats.
// ----------------------------------------------------------------------------

module testbench;

    import kbpfe_pkg::*;

    localparam int MAX_FRAME_BYTES = 12;
    localparam int READ_BYTES      = 16;
    localparam int KEY_DEPTH       = 16;

    // Cycles with no beat on either side before the run is declared hung
    localparam int STALL_LIMIT = 4000;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    kbpfe_in_t  req_data;
    logic       rsp_valid;
    logic       rsp_stall;
    kbpfe_out_t rsp_data;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;
    int items_sent;
    int quiet_cycles;

    // ------------------------------------------------------------------------
    // Mirror of the panel: command slots, bit capture, key queue and flags.
    // Every accepted request advances it once and queues the result the
    // engine owes for that beat.
    // ------------------------------------------------------------------------
    class panel_mirror;
        bit [7:0]    slot_bytes [MAX_FRAME_BYTES];
        int unsigned bus_len;
        int unsigned half_count;
        bit          rise_next;
        bit [7:0]    rx_bytes [READ_BYTES];
        bit [7:0]    module_latch [READ_BYTES];
        int unsigned rx_bit;
        int unsigned rx_byte;
        int unsigned rx_total;
        int unsigned tx_bit;
        int unsigned tx_byte;
        int unsigned tx_total;
        bit          saw_low;
        bit [7:0]    key_store [KEY_DEPTH];
        int unsigned key_fill;
        int unsigned key_rd;
        bit          busy;
        bit          alarm;
        bit          pending;
        bit          overflow;
        bit          clk_out;
        bit          pull_out;
        kbpfe_out_t  due_outputs [$];
        int          faults;
        int          beats_seen;

        function new();
            slot_bytes   = '{default: 8'h00};
            rx_bytes     = '{default: 8'h00};
            module_latch = '{default: 8'h00};
            key_store    = '{default: 8'h00};
            bus_len      = 0;
            half_count   = 0;
            rise_next    = 1'b1;
            rx_bit       = 0;
            rx_byte      = 0;
            rx_total     = 0;
            tx_bit       = 0;
            tx_byte      = 0;
            tx_total     = 0;
            saw_low      = 1'b0;
            key_fill     = 0;
            key_rd       = 0;
            busy         = 1'b0;
            alarm        = 1'b0;
            pending      = 1'b0;
            overflow     = 1'b0;
            clk_out      = 1'b0;
            pull_out     = 1'b0;
            faults       = 0;
            beats_seen   = 0;
        endfunction

        function bit is_accepted(bit [7:0] code);
            case (code)
                8'h00, 8'h05, 8'h0A, 8'h0F, 8'h11, 8'h16, 8'h1B, 8'h1C,
                8'h22, 8'h27, 8'h28, 8'h2D, 8'h82, 8'h87, 8'h88, 8'hAF,
                8'hB1, 8'hBB, 8'hDA, 8'hE1, 8'hF7, 8'h0B, 8'h0D, 8'h0E:
                    return 1'b1;
                default:
                    return 1'b0;
            endcase
        endfunction

        function void queue_key(bit [7:0] code);
            if (key_fill >= KEY_DEPTH)
            begin
                overflow = 1'b1;
            end
            else
            begin
                key_store[key_fill] = code;
                key_fill++;
            end
        endfunction

        // Falling phase, input side: shift one module bit in, stop bit alone
        function void take_sample(bit level);
            if (rx_byte >= READ_BYTES)
            begin
                return;
            end
            if (rx_bit < 8)
            begin
                if (!level)
                begin
                    saw_low = 1'b1;
                end
                rx_bytes[rx_byte] = {rx_bytes[rx_byte][6:0], level};
            end
            if (rx_total == 8)
            begin
                rx_bytes[1] = 8'h01;
                rx_bit      = 0;
                rx_byte++;
            end
            else if (rx_bit < 7)
            begin
                rx_bit++;
            end
            else
            begin
                rx_bit = 0;
                rx_byte++;
            end
            rx_total++;
        endfunction

        // Falling phase, output side: one inverted command bit or the stop bit
        function void shift_out_bit();
            if (tx_total == 8)
            begin
                pull_out = 1'b1;
                if (slot_bytes[0] == VERIFY_OPCODE)
                begin
                    pending = 1'b0;
                    if (rx_bytes[0] != IDLE_BYTE)
                    begin
                        if (key_fill >= KEY_DEPTH)
                            overflow = 1'b1;
                        else if (rx_bytes[0] == ALARM_BUS_A)
                            queue_key(ALARM_KEY_A);
                        else if (rx_bytes[0] == ALARM_BUS_B)
                            queue_key(ALARM_KEY_B);
                        else if (rx_bytes[0] == ALARM_BUS_C)
                            queue_key(ALARM_KEY_C);
                    end
                end
                tx_total++;
            end
            else if (tx_bit == 7)
            begin
                if (tx_byte < MAX_FRAME_BYTES && !slot_bytes[tx_byte][0])
                begin
                    pull_out = 1'b1;
                end
                tx_bit = 0;
                tx_total++;
                tx_byte++;
            end
            else if (tx_byte < bus_len && tx_byte < MAX_FRAME_BYTES)
            begin
                if (!slot_bytes[tx_byte][7 - tx_bit])
                begin
                    pull_out = 1'b1;
                end
                tx_bit++;
                tx_total++;
            end
        endfunction

        function void close_frame();
            clk_out = 1'b0;
            if (saw_low)
            begin
                saw_low      = 1'b0;
                module_latch = rx_bytes;
                if (rx_bytes[0] != IDLE_BYTE && slot_bytes[0] != VERIFY_OPCODE)
                begin
                    alarm = 1'b1;
                end
                if (rx_bytes[2] != IDLE_BYTE && slot_bytes[0] == PARTITION_OPCODE)
                begin
                    queue_key(rx_bytes[2]);
                end
            end
            rx_bytes = '{default: 8'h00};
            rx_bit   = 0;
            rx_byte  = 0;
            rx_total = 0;
            tx_bit   = 0;
            tx_byte  = 0;
            tx_total = 0;
            busy     = 1'b0;
        endfunction

        // Advance the mirror by one accepted request and queue its result
        function void take_request(kbpfe_in_t beat);
            kbpfe_out_t res;
            bit         was_busy;
            bit [7:0]   code;
            res      = '0;
            was_busy = busy;
            case (beat.command)
                CMD_LOAD:
                begin
                    if (!was_busy && beat.byte_index < MAX_FRAME_BYTES)
                        slot_bytes[beat.byte_index] = beat.byte_value;
                end
                CMD_START:
                begin
                    if (!was_busy)
                    begin
                        bus_len = (beat.frame_bytes > MAX_FRAME_BYTES) ?
                                  MAX_FRAME_BYTES : beat.frame_bytes;
                        half_count = 0;
                        busy       = 1'b1;
                        if (slot_bytes[0] == VERIFY_OPCODE)
                        begin
                            alarm   = 1'b0;
                            pending = 1'b1;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (was_busy)
                    begin
                        if (half_count < bus_len * 16 + FRAME_TAIL)
                        begin
                            if (rise_next)
                            begin
                                rise_next = 1'b0;
                                clk_out   = 1'b1;
                                pull_out  = 1'b0;
                            end
                            else
                            begin
                                rise_next = 1'b1;
                                clk_out   = 1'b0;
                                take_sample(beat.data_level);
                                shift_out_bit();
                            end
                            half_count = (half_count + 1) & 8'hFF;
                        end
                        else
                        begin
                            close_frame();
                            res.frame_done = 1'b1;
                        end
                    end
                end
                CMD_POP:
                begin
                    if (key_fill != 0)
                    begin
                        code = key_store[key_rd];
                        key_rd++;
                        if (key_rd >= key_fill)
                        begin
                            key_rd   = 0;
                            key_fill = 0;
                        end
                        res.key_code  = code;
                        res.key_valid = is_accepted(code);
                    end
                end
                CMD_READ:
                begin
                    if (beat.byte_index < READ_BYTES)
                        res.module_byte = module_latch[beat.byte_index];
                end
                default:
                begin
                end
            endcase
            res.clock_level         = clk_out;
            res.data_pull           = pull_out;
            res.busy_res            = busy;
            res.alarm_key_seen      = alarm;
            res.alarm_reply_pending = pending;
            res.key_overflow        = overflow;
            due_outputs.push_back(res);
        endfunction

        function void check_output(kbpfe_out_t got);
            kbpfe_out_t want;
            string      bad;
            beats_seen++;
            if (due_outputs.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("[%0t] result beat %0d arrived with nothing due: %h",
                             $time, beats_seen, got);
                return;
            end
            want = due_outputs.pop_front();
            bad  = "";
            if (got.clock_level !== want.clock_level)
                bad = {bad, " clock_level"};
            if (got.data_pull !== want.data_pull)
                bad = {bad, " data_pull"};
            if (got.busy_res !== want.busy_res)
                bad = {bad, " busy_res"};
            if (got.frame_done !== want.frame_done)
                bad = {bad, " frame_done"};
            if (got.key_valid !== want.key_valid)
                bad = {bad, " key_valid"};
            if (got.key_code !== want.key_code)
                bad = {bad, " key_code"};
            if (got.alarm_key_seen !== want.alarm_key_seen)
                bad = {bad, " alarm_key_seen"};
            if (got.alarm_reply_pending !== want.alarm_reply_pending)
                bad = {bad, " alarm_reply_pending"};
            if (got.key_overflow !== want.key_overflow)
                bad = {bad, " key_overflow"};
            if (got.module_byte !== want.module_byte)
                bad = {bad, " module_byte"};
            if (bad != "")
            begin
                faults++;
                if (faults <= 10)
                    $display("[%0t] result beat %0d wrong in%s: expected %h, got %h",
                             $time, beats_seen, bad, want, got);
            end
        endfunction
    endclass

    panel_mirror panel;

    keybus_panel_frame_engine
    #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .READ_BYTES      (READ_BYTES),
        .KEY_DEPTH       (KEY_DEPTH)
    )
    uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Fully random request: every field at any value its width allows,
    // unassigned command codes included
    function automatic kbpfe_in_t rand_beat();
        kbpfe_in_t b;
        b.command     = 3'($urandom_range(7));
        b.byte_index  = 4'($urandom_range(15));
        b.byte_value  = 8'($urandom_range(255));
        b.frame_bytes = 4'($urandom_range(15));
        b.data_level  = 1'($urandom_range(1));
        return b;
    endfunction

    // Offer one request beat and hold it until taken. Idle gaps are decided
    // before the beat goes out, so valid never looks at stall. The mirror is
    // advanced from this process, so the next beat can be chosen from the
    // panel state it will actually meet.
    task automatic send_beat(input kbpfe_in_t beat);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= beat;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        panel.take_request(beat);
        items_sent++;
    endtask

    // Short directed opening: field extremes, every command, the idle and
    // busy corner cases and a frame with no command bytes.
    task automatic run_directed();
        kbpfe_in_t b;
        // Fill every command slot first, so no frame ever sends an unwritten one
        for (int s = 0; s < MAX_FRAME_BYTES; s++)
        begin
            b            = rand_beat();
            b.command    = CMD_LOAD;
            b.byte_index = 4'(s);
            if (s == 0)
                b.byte_value = 8'h00;
            else if (s == 1)
                b.byte_value = 8'hFF;
            send_beat(b);
        end
        // Load past the last slot: dropped
        b            = rand_beat();
        b.command    = CMD_LOAD;
        b.byte_index = 4'd15;
        send_beat(b);
        // Unassigned command code
        b         = rand_beat();
        b.command = CMD_READ + 3'd3;
        send_beat(b);
        // Pop from an empty queue
        b         = rand_beat();
        b.command = CMD_POP;
        send_beat(b);
        // Reads at both ends of the module bytes
        b            = rand_beat();
        b.command    = CMD_READ;
        b.byte_index = 4'd15;
        send_beat(b);
        b.byte_index = 4'd0;
        send_beat(b);
        // Tick while idle: no effect
        b         = rand_beat();
        b.command = CMD_TICK;
        send_beat(b);
        // Frame with no command bytes, then a start while it runs
        b             = rand_beat();
        b.command     = CMD_START;
        b.frame_bytes = 4'd0;
        send_beat(b);
        b.frame_bytes = 4'd15;
        send_beat(b);
        // Module pulls the line low throughout; run until the frame closes
        while (panel.busy)
        begin
            b            = rand_beat();
            b.command    = CMD_TICK;
            b.data_level = 1'b0;
            send_beat(b);
        end
        b            = rand_beat();
        b.command    = CMD_READ;
        b.byte_index = 4'd0;
        send_beat(b);
    endtask

    // One complete frame: choose the opcode, reload a few slots, start, and
    // tick it to the end while the module side answers with a shaped reply.
    task automatic run_frame(input int drain_pct);
        kbpfe_in_t b;
        bit [7:0]  reply [READ_BYTES];
        int        pick;
        int        tick_no;
        int        k;
        bit        lvl;
        // Close any frame that a stray start left open
        while (panel.busy)
        begin
            b         = rand_beat();
            b.command = CMD_TICK;
            send_beat(b);
        end
        // Byte 0 decides how the frame is treated: verify, partition or other
        b            = rand_beat();
        b.command    = CMD_LOAD;
        b.byte_index = 4'd0;
        pick         = $urandom_range(3);
        if (pick == 0)
            b.byte_value = VERIFY_OPCODE;
        else if (pick == 1)
            b.byte_value = PARTITION_OPCODE;
        send_beat(b);
        repeat ($urandom_range(3))
        begin
            b         = rand_beat();
            b.command = CMD_LOAD;
            send_beat(b);
        end
        // Mostly short frames; now and then any length, saturated ones too
        b         = rand_beat();
        b.command = CMD_START;
        if ($urandom_range(9) != 0)
            b.frame_bytes = 4'($urandom_range(3));
        send_beat(b);
        // Module reply: byte 0 idle, an alarm key or random, later bytes idle or random
        pick = $urandom_range(4);
        case (pick)
            0:       reply[0] = IDLE_BYTE;
            1:       reply[0] = ALARM_BUS_A;
            2:       reply[0] = ALARM_BUS_B;
            3:       reply[0] = ALARM_BUS_C;
            default: reply[0] = 8'($urandom_range(255));
        endcase
        for (int j = 1; j < READ_BYTES; j++)
        begin
            reply[j] = ($urandom_range(3) == 0) ? IDLE_BYTE : 8'($urandom_range(255));
        end
        // Now and then a silent module, stop bit included: nothing gets latched
        if ($urandom_range(5) == 0)
        begin
            reply = '{default: IDLE_BYTE};
        end
        tick_no = 0;
        while (panel.busy)
        begin
            // Stray beats mid-frame; ticks among them would skew the reply
            if ($urandom_range(9) == 0)
            begin
                b = rand_beat();
                if (b.command == CMD_TICK ||
                    (b.command == CMD_POP && $urandom_range(99) >= drain_pct * 4))
                    b.command = CMD_READ;
                send_beat(b);
            end
            // Odd ticks are falling phases; k counts the module bits
            k = tick_no / 2;
            if (k < 8)
                lvl = reply[0][7 - k];
            else if (k == 8)
                lvl = reply[1][0];
            else
                lvl = reply[(k - 9) / 8 + 2][7 - (k - 9) % 8];
            b            = rand_beat();
            b.command    = CMD_TICK;
            b.data_level = lvl;
            send_beat(b);
            tick_no++;
        end
    endtask

    // Drain the key queue and peek at the module bytes
    task automatic pop_burst();
        kbpfe_in_t b;
        repeat ($urandom_range(1, 20))
        begin
            b         = rand_beat();
            b.command = ($urandom_range(3) == 0) ? CMD_READ : CMD_POP;
            send_beat(b);
        end
    endtask

    // Mix of whole frames, pop bursts and stray beats. A low drain share lets
    // keys pile up until the queue overflows.
    task automatic gen_traffic(input int count, input int drain_pct);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < drain_pct)
                pop_burst();
            else if (pick < drain_pct + 8)
                send_beat(rand_beat());
            else
                run_frame(drain_pct);
        end
    endtask

    // Result side: check every beat taken, then pick the next stall level.
    // A requested hold-off keeps stall high for a counted stretch.
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                panel.check_output(rsp_data);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < sink_stall_pct);
            end
        end
    end

    // Watchdog: advance while beats keep moving on either side
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n          <= 1'b0;
        req_valid      <= 1'b0;
        req_data       <= '0;
        src_idle_pct   = 12;
        sink_stall_pct = 73;
        hold_left      = 0;
        items_sent     = 0;
        panel          = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        // Busy sender, heavily stalled receiver
        gen_traffic(430, 15);

        // Pause the sender until every due result has come back
        req_valid <= 1'b0;
        while (panel.due_outputs.size() != 0)
        begin
            @(posedge clk);
        end

        // Sparse sender, light stalls; open with a long hold-off so the
        // engine fills up and pushes back on the request side
        src_idle_pct   = 73;
        sink_stall_pct = 12;
        hold_left      = 80;
        gen_traffic(450, 15);

        // Full rate both ways, keys left to pile up
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        gen_traffic(450, 2);

        req_valid <= 1'b0;
        while (panel.due_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        // Allow for the two-stage pipe to show any stray beat
        repeat (8) @(posedge clk);

        if (panel.faults == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: keybus_panel_frame_engine.f
hdl/kbpfe_pkg.sv
hdl/keybus_panel_frame_engine.sv
hdl/kbpfe_checker.sv
dv/testbench.sv
